// File: src/rsi_pkg.sv
// ----------------------------------------------------------------------------
// Ray segment intersection package
// Shared widths, beat types and the divider stage record.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned DirWidth   = 16;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned DetWidth   = DiffWidth + DirWidth + 1;
  localparam int unsigned UnumWidth  = 2 * DiffWidth + 1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DirWidth-1:0]   dir_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;

  typedef struct packed {
    coord_t wall_start_x;
    coord_t wall_start_y;
    coord_t wall_end_x;
    coord_t wall_end_y;
    coord_t ray_origin_x;
    coord_t ray_origin_y;
    dir_t   ray_dir_x;
    dir_t   ray_dir_y;
  } ray_in_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_x;
    coord_t hit_y;
  } ray_out_t;

  typedef struct packed {
    logic                hit;
    logic [DetWidth-1:0] aden;
    logic [DetWidth-1:0] rem;
    logic [FracBits-1:0] quot;
    coord_t              x1;
    coord_t              y1;
    diff_t               wx;
    diff_t               wy;
  } div_t;

endpackage

// File: src/rsi_div_stage.sv
// ----------------------------------------------------------------------------
// Ray segment intersection divider stage
// One registered restoring step of the t quotient, one bit per stage.
// ----------------------------------------------------------------------------
module rsi_div_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  rsi_pkg::div_t data_i,
  output logic         valid_o,
  output rsi_pkg::div_t data_o
);

  logic [rsi_pkg::DetWidth:0] rem2;
  logic                       ge;
  rsi_pkg::div_t              data_d;
  rsi_pkg::div_t              data_q;
  logic                       valid_q;

  assign rem2 = {data_i.rem, 1'b0};
  assign ge   = rem2 >= {1'b0, data_i.aden};

  always_comb begin
    data_d      = data_i;
    data_d.quot = {data_i.quot[rsi_pkg::FracBits-2:0], ge};
    data_d.rem  = ge ? rsi_pkg::DetWidth'(rem2 - {1'b0, data_i.aden})
                     : rsi_pkg::DetWidth'(rem2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/ray_segment_intersection.sv
// ----------------------------------------------------------------------------
// Ray segment intersection
// Pipelined 2D ray against wall segment hit test with hit point.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the output side keeps up, and returns one
// result beat per input beat, in order. The pipeline is made up of the 16
// stages of the restoring divider that forms the Q0.16 segment parameter,
// plus five stages of differences, products, determinant, sign tests and
// magnitude compare, and two of hit point multiply and add. Every stage
// holds its own valid bit, so a stall at the output only holds beats that
// are queued behind it and bubbles close up.
module ray_segment_intersection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rsi_pkg::ray_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsi_pkg::ray_out_t  out_data_o
);

  localparam int unsigned DivSteps = rsi_pkg::FracBits;
  localparam int unsigned ProdWidth = rsi_pkg::DetWidth - 1;
  localparam int unsigned UprodWidth = rsi_pkg::UnumWidth - 1;
  localparam int unsigned MulWidth = rsi_pkg::DiffWidth + rsi_pkg::FracBits + 1;

  typedef logic signed [ProdWidth-1:0]             prod_t;
  typedef logic signed [UprodWidth-1:0]            uprod_t;
  typedef logic signed [rsi_pkg::DetWidth-1:0]     det_t;
  typedef logic signed [rsi_pkg::UnumWidth-1:0]    unum_t;
  typedef logic signed [MulWidth-1:0]              mul_t;

  // enables
  logic en1, en2, en3, en4, en5, en6, en_out;
  logic [DivSteps-1:0] div_en;

  // stage 1: differences
  logic              s1_v_q;
  rsi_pkg::diff_t    s1_a_d, s1_b_d, s1_c_d, s1_e_d, s1_wx_d, s1_wy_d;
  rsi_pkg::diff_t    s1_a_q, s1_b_q, s1_c_q, s1_e_q, s1_wx_q, s1_wy_q;
  rsi_pkg::coord_t   s1_x1_q, s1_y1_q;
  rsi_pkg::dir_t     s1_dx_q, s1_dy_q;

  // stage 2: products
  logic              s2_v_q;
  prod_t             s2_p1_d, s2_p2_d, s2_p3_d, s2_p4_d;
  prod_t             s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q;
  uprod_t            s2_p5_d, s2_p6_d, s2_p5_q, s2_p6_q;
  rsi_pkg::coord_t   s2_x1_q, s2_y1_q;
  rsi_pkg::diff_t    s2_wx_q, s2_wy_q;

  // stage 3: determinant and numerators
  logic              s3_v_q;
  det_t              s3_den_d, s3_tnum_d, s3_den_q, s3_tnum_q;
  unum_t             s3_unum_d, s3_unum_q;
  rsi_pkg::coord_t   s3_x1_q, s3_y1_q;
  rsi_pkg::diff_t    s3_wx_q, s3_wy_q;

  // stage 4: signs and magnitudes
  logic              s4_v_q;
  logic              s4_pre_d, s4_pre_q;
  logic [rsi_pkg::DetWidth-1:0] s4_aden_d, s4_rem_d, s4_aden_q, s4_rem_q;
  rsi_pkg::coord_t   s4_x1_q, s4_y1_q;
  rsi_pkg::diff_t    s4_wx_q, s4_wy_q;
  logic              dneg, tneg, uneg;

  // stage 5: magnitude compare, divider entry
  logic              s5_v_q;
  rsi_pkg::div_t     s5_d, s5_q;

  // divider chain
  logic [DivSteps:0] div_v;
  rsi_pkg::div_t     div_data [DivSteps+1];

  // stage 6: hit point products
  logic              s6_v_q;
  logic              s6_hit_q;
  mul_t              s6_mx_d, s6_my_d, s6_mx_q, s6_my_q;
  rsi_pkg::coord_t   s6_x1_q, s6_y1_q;

  // output register
  logic              out_v_q;
  rsi_pkg::ray_out_t out_d, out_q;
  mul_t              fx, fy;

  // ---------------------------------------------------------------- enables
  assign en_out = !out_v_q || out_ready_i;
  assign en6    = !s6_v_q || en_out;
  assign en5    = !s5_v_q || div_en[0];
  assign en4    = !s4_v_q || en5;
  assign en3    = !s3_v_q || en4;
  assign en2    = !s2_v_q || en3;
  assign en1    = !s1_v_q || en2;
  assign in_ready_o = en1;

  // ---------------------------------------------------------------- stage 1
  assign s1_a_d  = rsi_pkg::DiffWidth'(in_data_i.wall_start_x)
                 - rsi_pkg::DiffWidth'(in_data_i.wall_end_x);
  assign s1_b_d  = rsi_pkg::DiffWidth'(in_data_i.wall_start_y)
                 - rsi_pkg::DiffWidth'(in_data_i.wall_end_y);
  assign s1_c_d  = rsi_pkg::DiffWidth'(in_data_i.wall_start_x)
                 - rsi_pkg::DiffWidth'(in_data_i.ray_origin_x);
  assign s1_e_d  = rsi_pkg::DiffWidth'(in_data_i.wall_start_y)
                 - rsi_pkg::DiffWidth'(in_data_i.ray_origin_y);
  assign s1_wx_d = rsi_pkg::DiffWidth'(in_data_i.wall_end_x)
                 - rsi_pkg::DiffWidth'(in_data_i.wall_start_x);
  assign s1_wy_d = rsi_pkg::DiffWidth'(in_data_i.wall_end_y)
                 - rsi_pkg::DiffWidth'(in_data_i.wall_start_y);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_a_q  <= s1_a_d;
      s1_b_q  <= s1_b_d;
      s1_c_q  <= s1_c_d;
      s1_e_q  <= s1_e_d;
      s1_wx_q <= s1_wx_d;
      s1_wy_q <= s1_wy_d;
      s1_x1_q <= in_data_i.wall_start_x;
      s1_y1_q <= in_data_i.wall_start_y;
      s1_dx_q <= in_data_i.ray_dir_x;
      s1_dy_q <= in_data_i.ray_dir_y;
    end
  end

  // ---------------------------------------------------------------- stage 2
  assign s2_p1_d = prod_t'(s1_b_q) * prod_t'(s1_dx_q);
  assign s2_p2_d = prod_t'(s1_a_q) * prod_t'(s1_dy_q);
  assign s2_p3_d = prod_t'(s1_e_q) * prod_t'(s1_dx_q);
  assign s2_p4_d = prod_t'(s1_c_q) * prod_t'(s1_dy_q);
  assign s2_p5_d = uprod_t'(s1_a_q) * uprod_t'(s1_e_q);
  assign s2_p6_d = uprod_t'(s1_b_q) * uprod_t'(s1_c_q);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_p1_q <= s2_p1_d;
      s2_p2_q <= s2_p2_d;
      s2_p3_q <= s2_p3_d;
      s2_p4_q <= s2_p4_d;
      s2_p5_q <= s2_p5_d;
      s2_p6_q <= s2_p6_d;
      s2_x1_q <= s1_x1_q;
      s2_y1_q <= s1_y1_q;
      s2_wx_q <= s1_wx_q;
      s2_wy_q <= s1_wy_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  assign s3_den_d  = det_t'(s2_p1_q) - det_t'(s2_p2_q);
  assign s3_tnum_d = det_t'(s2_p3_q) - det_t'(s2_p4_q);
  assign s3_unum_d = unum_t'(s2_p5_q) - unum_t'(s2_p6_q);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_den_q  <= s3_den_d;
      s3_tnum_q <= s3_tnum_d;
      s3_unum_q <= s3_unum_d;
      s3_x1_q   <= s2_x1_q;
      s3_y1_q   <= s2_y1_q;
      s3_wx_q   <= s2_wx_q;
      s3_wy_q   <= s2_wy_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  assign dneg = s3_den_q[rsi_pkg::DetWidth-1];
  assign tneg = s3_tnum_q[rsi_pkg::DetWidth-1];
  assign uneg = s3_unum_q[rsi_pkg::UnumWidth-1];

  assign s4_pre_d  = (s3_den_q != '0) && (s3_tnum_q != '0) && (tneg == dneg)
                   && (s3_unum_q != '0) && (uneg != dneg);
  assign s4_aden_d = dneg ? rsi_pkg::DetWidth'(-s3_den_q) : rsi_pkg::DetWidth'(s3_den_q);
  assign s4_rem_d  = tneg ? rsi_pkg::DetWidth'(-s3_tnum_q) : rsi_pkg::DetWidth'(s3_tnum_q);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_pre_q  <= s4_pre_d;
      s4_aden_q <= s4_aden_d;
      s4_rem_q  <= s4_rem_d;
      s4_x1_q   <= s3_x1_q;
      s4_y1_q   <= s3_y1_q;
      s4_wx_q   <= s3_wx_q;
      s4_wy_q   <= s3_wy_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  always_comb begin
    s5_d.hit  = s4_pre_q && (s4_rem_q < s4_aden_q);
    s5_d.aden = s4_aden_q;
    s5_d.rem  = s4_rem_q;
    s5_d.quot = '0;
    s5_d.x1   = s4_x1_q;
    s5_d.y1   = s4_y1_q;
    s5_d.wx   = s4_wx_q;
    s5_d.wy   = s4_wy_q;
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_q <= s5_d;
    end
  end

  // ---------------------------------------------------------------- divider
  assign div_v[0]    = s5_v_q;
  assign div_data[0] = s5_q;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    if (k == DivSteps - 1) begin : g_last
      assign div_en[k] = !div_v[k+1] || en6;
    end else begin : g_mid
      assign div_en[k] = !div_v[k+1] || div_en[k+1];
    end

    rsi_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (div_en[k]),
      .valid_i (div_v[k]),
      .data_i  (div_data[k]),
      .valid_o (div_v[k+1]),
      .data_o  (div_data[k+1])
    );
  end

  // ---------------------------------------------------------------- stage 6
  assign s6_mx_d = mul_t'(div_data[DivSteps].wx)
                 * mul_t'({1'b0, div_data[DivSteps].quot});
  assign s6_my_d = mul_t'(div_data[DivSteps].wy)
                 * mul_t'({1'b0, div_data[DivSteps].quot});

  always_ff @(posedge clk_i) begin
    if (en6) begin
      s6_hit_q <= div_data[DivSteps].hit;
      s6_mx_q  <= s6_mx_d;
      s6_my_q  <= s6_my_d;
      s6_x1_q  <= div_data[DivSteps].x1;
      s6_y1_q  <= div_data[DivSteps].y1;
    end
  end

  // ---------------------------------------------------------------- output
  assign fx = s6_mx_q >>> rsi_pkg::FracBits;
  assign fy = s6_my_q >>> rsi_pkg::FracBits;

  always_comb begin
    out_d.hit   = s6_hit_q;
    out_d.hit_x = s6_hit_q ? rsi_pkg::CoordWidth'(mul_t'(s6_x1_q) + fx) : '0;
    out_d.hit_y = s6_hit_q ? rsi_pkg::CoordWidth'(mul_t'(s6_y1_q) + fy) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= in_valid_i;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (en4) begin
        s4_v_q <= s3_v_q;
      end
      if (en5) begin
        s5_v_q <= s4_v_q;
      end
      if (en6) begin
        s6_v_q <= div_v[DivSteps];
      end
      if (en_out) begin
        out_v_q <= s6_v_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.hit_x == '0 && out_data_o.hit_y == '0)
    else $error("miss beat carries a non-zero point");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> in_ready_o)
    else $error("input held off with an empty first stage");

  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_v_q)
    else $error("accepted beat lost at the first stage");

  a_out_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s6_v_q && !out_valid_o |=> out_valid_o)
    else $error("finished beat not moved to the output register");
`endif

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Ray segment intersection testbench
// Drives wall and ray beats through the valid/ready input, predicts each hit
// flag and hit point with exact integer arithmetic, and checks every result
// beat in order. A table of directed probes comes first, then aimed, parallel
// and raw random beats. Both sides idle in random bursts, and the output side
// holds off once long enough to back the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsi_pkg::*;

  localparam int RandomBeats = 700;
  localparam int TailBeats   = 100;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 40;
  localparam int NumProbes   = 20;

  localparam ray_out_t Miss = '{1'b0, 16'sd0, 16'sd0};

  typedef struct packed {
    ray_in_t  beat;
    logic     typed;
    ray_out_t want;
  } probe_t;

  localparam probe_t Probes[NumProbes] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, Miss},
    '{'{160, -160, 160, 160, 0, 0, 16384, 0}, 1'b1, '{1'b1, 160, 0}},
    '{'{160, -160, 160, 160, 0, 0, -16384, 0}, 1'b1, Miss},
    '{'{160, -160, 160, 160, 0, -160, 16384, 0}, 1'b1, Miss},
    '{'{160, -160, 160, 160, 0, 160, 16384, 0}, 1'b1, Miss},
    '{'{160, -160, 160, 160, 160, 0, 16384, 0}, 1'b1, Miss},
    '{'{-160, 80, 160, 80, 0, 0, 16384, 0}, 1'b1, Miss},
    '{'{160, -160, 160, 160, 0, 0, 0, 0}, 1'b1, Miss},
    '{'{-1, -1, -1, -1, -1, -1, -1, -1}, 1'b1, Miss},
    '{'{32767, -32768, 32767, 32767, 32766, -32768, 16384, 1}, 1'b0, Miss},
    '{'{-32768, -32768, 32767, 32767, 32767, -32768, -16384, 16384}, 1'b0, Miss},
    '{'{32767, 32767, -32768, -32768, -32768, 32767, 16384, -16384}, 1'b0, Miss},
    '{'{160, -160, 160, 160, 0, 0, -32768, 32767}, 1'b0, Miss},
    '{'{160, -160, 160, 160, 0, 0, 32767, -32768}, 1'b0, Miss},
    '{'{-1000, -333, -7, -1111, -500, 500, 0, -16384}, 1'b0, Miss},
    '{'{-37, -91, -3, -100, -80, -20, 16384, 16384}, 1'b0, Miss},
    '{'{160, 160, -160, -160, 0, -160, -16384, 16384}, 1'b0, Miss},
    '{'{21845, -21846, -21846, 21845, 21845, 21845, -21846, 21845}, 1'b0, Miss},
    '{'{-21846, 21845, 21845, -21846, -21846, -21846, 21845, -21846}, 1'b0, Miss},
    '{'{-32768, 0, 32767, 0, 0, -32768, 0, 16384}, 1'b0, Miss}
  };

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  ray_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ray_out_t out_data_o;

  ray_out_t pending_hits[$];
  ray_out_t head_hit;
  int       mismatches  = 0;
  int       beats_in    = 0;
  int       quiet_count = 0;
  int       gap_pct     = 0;
  bit       tail_phase  = 1'b0;
  bit       hold_done   = 1'b0;

  ray_segment_intersection dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic ray_out_t cast_ray(ray_in_t b);
    longint x1, y1, x2, y2, x3, y3, dx, dy;
    longint det, t_num, u_num, det_mag, t_mag, frac, px, py;
    ray_out_t r;
    x1 = longint'($signed(b.wall_start_x));
    y1 = longint'($signed(b.wall_start_y));
    x2 = longint'($signed(b.wall_end_x));
    y2 = longint'($signed(b.wall_end_y));
    x3 = longint'($signed(b.ray_origin_x));
    y3 = longint'($signed(b.ray_origin_y));
    dx = longint'($signed(b.ray_dir_x));
    dy = longint'($signed(b.ray_dir_y));
    det   = (y1 - y2) * dx - (x1 - x2) * dy;
    t_num = (y1 - y3) * dx - (x1 - x3) * dy;
    u_num = (x1 - x2) * (y1 - y3) - (y1 - y2) * (x1 - x3);
    det_mag = det < 0 ? -det : det;
    t_mag   = t_num < 0 ? -t_num : t_num;
    r = Miss;
    if (det != 0 && t_num != 0 && ((t_num < 0) == (det < 0)) && t_mag < det_mag &&
        u_num != 0 && ((u_num < 0) != (det < 0))) begin
      frac = (t_mag << FracBits) / det_mag;
      px = x1 + (((x2 - x1) * frac) >>> FracBits);
      py = y1 + (((y2 - y1) * frac) >>> FracBits);
      r.hit   = 1'b1;
      r.hit_x = px[CoordWidth-1:0];
      r.hit_y = py[CoordWidth-1:0];
    end
    return r;
  endfunction

  function automatic longint pick_coord(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint pick_span();
    case ($urandom_range(0, 2))
      0:       return 32767;
      1:       return 2047;
      default: return 127;
    endcase
  endfunction

  // Ray from a random origin towards a random point on the wall, or straight away from it when reverse is set.
  function automatic ray_in_t aim_ray(bit reverse);
    longint span, x1, y1, x2, y2, ox, oy, k, px, py, vx, vy, m;
    ray_in_t b;
    span = pick_span();
    x1 = pick_coord(span);
    y1 = pick_coord(span);
    x2 = pick_coord(span);
    y2 = pick_coord(span);
    ox = pick_coord(span);
    oy = pick_coord(span);
    k  = longint'($urandom_range(0, 256));
    px = x1 + (x2 - x1) * k / 256;
    py = y1 + (y2 - y1) * k / 256;
    vx = px - ox;
    vy = py - oy;
    m  = (vx < 0 ? -vx : vx) > (vy < 0 ? -vy : vy) ? (vx < 0 ? -vx : vx)
                                                   : (vy < 0 ? -vy : vy);
    if (m == 0) m = 1;
    vx = vx * 16384 / m;
    vy = vy * 16384 / m;
    if (reverse) begin
      vx = -vx;
      vy = -vy;
    end
    b.wall_start_x = coord_t'(x1);
    b.wall_start_y = coord_t'(y1);
    b.wall_end_x   = coord_t'(x2);
    b.wall_end_y   = coord_t'(y2);
    b.ray_origin_x = coord_t'(ox);
    b.ray_origin_y = coord_t'(oy);
    b.ray_dir_x    = dir_t'(vx);
    b.ray_dir_y    = dir_t'(vy);
    return b;
  endfunction

  function automatic ray_in_t make_beat();
    ray_in_t b;
    int      kind;
    kind = $urandom_range(0, 19);
    if (kind <= 11) begin
      b = aim_ray(1'b0);
    end else if (kind <= 13) begin
      b = aim_ray(1'b1);
    end else if (kind <= 16) begin
      b = ray_in_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (kind == 17) begin
      b = aim_ray(1'b0);
      if ($urandom_range(0, 1) == 0) begin
        b.wall_end_y = b.wall_start_y;
        b.ray_dir_y  = '0;
      end else begin
        b.wall_end_x = b.wall_start_x;
        b.ray_dir_x  = '0;
      end
    end else if (kind == 18) begin
      b = aim_ray(1'b0);
      b.ray_dir_x = dir_t'($urandom);
      b.ray_dir_y = dir_t'($urandom);
    end else begin
      b = aim_ray(1'b0);
      b.ray_dir_x = '0;
      b.ray_dir_y = '0;
    end
    return b;
  endfunction

  task automatic send_beat(input ray_in_t b, input ray_out_t want);
    if (!tail_phase && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_hits.push_back(want);
    beats_in++;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumProbes; i++) begin
      send_beat(Probes[i].beat, Probes[i].typed ? Probes[i].want
                                                : cast_ray(Probes[i].beat));
    end
    for (int i = 0; i < RandomBeats; i++) begin
      ray_in_t b;
      if (i % 32 == 0) gap_pct = $urandom_range(0, 2) * 25;
      if (i >= RandomBeats - TailBeats) tail_phase = 1'b1;
      b = make_beat();
      send_beat(b, cast_ray(b));
    end
    in_valid_i <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int stall_pct;
    int cycles;
    stall_pct = 0;
    cycles    = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles % 64 == 0) stall_pct = $urandom_range(0, 2) * 20;
      if (!hold_done && beats_in >= 120) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        $error("result beat with nothing pending: %p", out_data_o);
        mismatches++;
      end else begin
        head_hit = pending_hits.pop_front();
        if (out_data_o.hit !== head_hit.hit) begin
          $error("hit: expected %0d, got %0d", head_hit.hit, out_data_o.hit);
          mismatches++;
        end
        if (out_data_o.hit_x !== head_hit.hit_x) begin
          $error("hit_x: expected %0d, got %0d", $signed(head_hit.hit_x),
                 $signed(out_data_o.hit_x));
          mismatches++;
        end
        if (out_data_o.hit_y !== head_hit.hit_y) begin
          $error("hit_y: expected %0d, got %0d", $signed(head_hit.hit_y),
                 $signed(out_data_o.hit_y));
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_count <= 0;
      end else if (quiet_count >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

endmodule

// File: ray_segment_intersection.f
src/rsi_pkg.sv
src/rsi_div_stage.sv
src/ray_segment_intersection.sv
test/tb_top.sv
